// File: design/frame_change_classifier_unit_macros.svh
// Assertion macros shared by the frame change classifier.
`ifndef FRAME_CHANGE_CLASSIFIER_UNIT_MACROS_SVH
`define FRAME_CHANGE_CLASSIFIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/fcc_pkg.sv
// Package with the types, constants and codes of the frame change classifier.
`default_nettype none

package fcc_pkg;

   // Raster geometry.
   localparam int MAX_DIM  = 8192;
   localparam int DIM_W    = $clog2(MAX_DIM);
   localparam int FW_W     = DIM_W + 1;
   localparam int STRIDE_W = 5;
   localparam int STEP_W   = $clog2(DIM_W);

   // Field widths.
   localparam int CH_W     = 8;
   localparam int LUMA_W   = 24;
   localparam int CNT_W    = 27;
   localparam int SUM_W    = 34;
   localparam int PPM_W    = 20;
   localparam int MEAN_W   = 8;
   localparam int MUL_W    = CNT_W + PPM_W;
   localparam int MMUL_W   = CNT_W + MEAN_W;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [PPM_W-1:0] PPM_ONE = 20'd1000000;

   // Rec.709 luma weights, unsigned Q0.16, summing to one.
   localparam logic [15:0] LUMA_KR = 16'd13933;
   localparam logic [15:0] LUMA_KG = 16'd46871;
   localparam logic [15:0] LUMA_KB = 16'd4732;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_STRIDE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUPLICATE_PPM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_PPM          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_MEAN_DIFF    = 3'd5;

   typedef enum logic [1:0] {
      VERDICT_UPDATE    = 2'd0,
      VERDICT_DUPLICATE = 2'd1,
      VERDICT_CUT       = 2'd2
   } verdict_type;

   // One accepted pixel pair with its grid flag.
   typedef struct packed {
      logic [CH_W-1:0] cur_red;
      logic [CH_W-1:0] cur_green;
      logic [CH_W-1:0] cur_blue;
      logic [CH_W-1:0] ref_red;
      logic [CH_W-1:0] ref_green;
      logic [CH_W-1:0] ref_blue;
      logic            have_reference;
      logic            last_pixel;
      logic            sample;
   } pix_type;

   // Rounded luma difference of one pixel pair.
   typedef struct packed {
      logic [CH_W-1:0] diff;
      logic            have_reference;
      logic            last_pixel;
      logic            sample;
   } diff_type;

   // Frame totals handed to the verdict stages.
   typedef struct packed {
      logic [CNT_W-1:0] changed;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } tot_type;

   // Verdict thresholds.
   typedef struct packed {
      logic [PPM_W-1:0]  duplicate_ppm;
      logic [PPM_W-1:0]  cut_ppm;
      logic [MEAN_W-1:0] cut_mean_diff;
   } limit_type;

   // One result item.
   typedef struct packed {
      logic [CNT_W-1:0] sample_count;
      logic [SUM_W-1:0] diff_sum;
      logic [CNT_W-1:0] changed_count;
      verdict_type      verdict;
   } result_type;

endpackage

`default_nettype wire

// File: design/fcc_position.sv
// Raster position tracking and sampling grid phase for the frame change classifier.
`default_nettype none

module fcc_position (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pix_accept,
   input  logic                          pix_last,
   input  logic [fcc_pkg::FW_W-1:0]      frame_width,
   input  logic [fcc_pkg::STRIDE_W-1:0]  sample_stride,
   input  logic                          stride_we,
   input  logic [fcc_pkg::STRIDE_W-1:0]  stride_new,
   output logic                          sample,
   output logic                          busy
);
   import fcc_pkg::*;

   // One restoring step of a remainder: shift in a bit, subtract the divisor if it fits.
   function automatic logic [STRIDE_W-1:0] rem_step(input logic [STRIDE_W-1:0] r,
                                                    input logic                b,
                                                    input logic [STRIDE_W-1:0] dv);
      logic [STRIDE_W:0] t;
      begin
         t = {r, b};
         if (t >= {1'b0, dv}) begin
            t = t - {1'b0, dv};
         end
         rem_step = t[STRIDE_W-1:0];
      end
   endfunction

   logic [DIM_W-1:0]    column_ff, column_in;
   logic [DIM_W-1:0]    row_ff, row_in;
   logic [STRIDE_W-1:0] col_phase_ff, col_phase_in;
   logic [STRIDE_W-1:0] row_phase_ff, row_phase_in;
   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [STRIDE_W-1:0] rem_col_ff, rem_col_in;
   logic [STRIDE_W-1:0] rem_row_ff, rem_row_in;
   logic [STRIDE_W-1:0] div_ff, div_in;

   logic [STRIDE_W-1:0] stride_eff;
   logic [STRIDE_W-1:0] stride_new_eff;
   logic [FW_W-1:0]     width_eff;
   logic                col_wrap;
   logic                row_end;
   logic [STRIDE_W:0]   col_step;
   logic [STRIDE_W:0]   row_step;
   logic [STRIDE_W-1:0] rem_col_next;
   logic [STRIDE_W-1:0] rem_row_next;

   // A stride of zero acts as one; the width is clamped to the supported raster.
   assign stride_eff     = (sample_stride == '0) ? STRIDE_W'(1) : sample_stride;
   assign stride_new_eff = (stride_new == '0) ? STRIDE_W'(1) : stride_new;
   assign width_eff      = (frame_width == '0) ? FW_W'(1) :
                           (frame_width > FW_W'(MAX_DIM)) ? FW_W'(MAX_DIM) : frame_width;

   assign col_wrap = ({1'b0, column_ff} + FW_W'(1)) >= width_eff;
   assign row_end  = (row_ff == {DIM_W{1'b1}});
   assign col_step = {1'b0, col_phase_ff} + (STRIDE_W + 1)'(1);
   assign row_step = {1'b0, row_phase_ff} + (STRIDE_W + 1)'(1);

   assign rem_col_next = rem_step(rem_col_ff, column_ff[step_ff], div_ff);
   assign rem_row_next = rem_step(rem_row_ff, row_ff[step_ff], div_ff);

   assign sample = (col_phase_ff == '0) && (row_phase_ff == '0);
   assign busy   = busy_ff;

   // Counter update per accepted pixel, and a bit-serial phase rebuild after a stride change.
   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      rem_col_in   = rem_col_ff;
      rem_row_in   = rem_row_ff;
      div_in       = div_ff;
      if (stride_we) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(DIM_W - 1);
         rem_col_in = '0;
         rem_row_in = '0;
         div_in     = stride_new_eff;
      end else if (busy_ff) begin
         rem_col_in = rem_col_next;
         rem_row_in = rem_row_next;
         step_in    = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in      = 1'b0;
            col_phase_in = rem_col_next;
            row_phase_in = rem_row_next;
         end
      end else if (pix_accept) begin
         if (pix_last) begin
            column_in    = '0;
            row_in       = '0;
            col_phase_in = '0;
            row_phase_in = '0;
         end else if (col_wrap) begin
            column_in    = '0;
            col_phase_in = '0;
            row_in       = row_ff + DIM_W'(1);
            if (row_end || (row_step >= {1'b0, stride_eff})) begin
               row_phase_in = '0;
            end else begin
               row_phase_in = row_step[STRIDE_W-1:0];
            end
         end else begin
            column_in = column_ff + DIM_W'(1);
            if (col_step >= {1'b0, stride_eff}) begin
               col_phase_in = '0;
            end else begin
               col_phase_in = col_step[STRIDE_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
      end else begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
      end
      rem_col_ff <= rem_col_in;
      rem_row_ff <= rem_row_in;
      div_ff     <= div_in;
   end

endmodule

`default_nettype wire

// File: design/fcc_luma_diff.sv
// Input register and luma difference stages of the frame change classifier.
`default_nettype none

module fcc_luma_diff (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fcc_pkg::pix_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output fcc_pkg::diff_type  out_data
);
   import fcc_pkg::*;

   typedef struct packed {
      logic [LUMA_W-1:0] luma_cur;
      logic [LUMA_W-1:0] luma_ref;
      logic              have_reference;
      logic              last_pixel;
      logic              sample;
   } luma_type;

   // Weighted sum of one RGB triple, in 1/65536 of an 8-bit step.
   function automatic logic [LUMA_W-1:0] luma(input logic [CH_W-1:0] r,
                                              input logic [CH_W-1:0] g,
                                              input logic [CH_W-1:0] b);
      begin
         luma = LUMA_W'(LUMA_KR) * LUMA_W'(r) + LUMA_W'(LUMA_KG) * LUMA_W'(g)
              + LUMA_W'(LUMA_KB) * LUMA_W'(b);
      end
   endfunction

   logic     s1_valid_ff, s1_valid_in;
   pix_type  s1_ff, s1_in;
   logic     s2_valid_ff, s2_valid_in;
   luma_type s2_ff, s2_in;
   logic     s3_valid_ff, s3_valid_in;
   diff_type s3_ff, s3_in;

   logic              s2_ready;
   logic              s3_ready;
   logic [LUMA_W-1:0] abs_diff;
   logic [LUMA_W:0]   rounded;

   // Each stage moves on when the next one is empty or moving too.
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign in_ready = !s1_valid_ff || s2_ready;

   // Absolute difference, rounded half up to a whole 8-bit step.
   assign abs_diff = (s2_ff.luma_cur >= s2_ff.luma_ref) ? (s2_ff.luma_cur - s2_ff.luma_ref)
                                                        : (s2_ff.luma_ref - s2_ff.luma_cur);
   assign rounded  = {1'b0, abs_diff} + (LUMA_W + 1)'(32768);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (in_ready) begin
         s1_valid_in = in_valid;
         s1_in       = in_data;
      end

      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (s2_ready) begin
         s2_valid_in          = s1_valid_ff;
         s2_in.luma_cur       = luma(s1_ff.cur_red, s1_ff.cur_green, s1_ff.cur_blue);
         s2_in.luma_ref       = luma(s1_ff.ref_red, s1_ff.ref_green, s1_ff.ref_blue);
         s2_in.have_reference = s1_ff.have_reference;
         s2_in.last_pixel     = s1_ff.last_pixel;
         s2_in.sample         = s1_ff.sample;
      end

      s3_valid_in = s3_valid_ff;
      s3_in       = s3_ff;
      if (s3_ready) begin
         s3_valid_in          = s2_valid_ff;
         s3_in.diff           = rounded[LUMA_W-1:16];
         s3_in.have_reference = s2_ff.have_reference;
         s3_in.last_pixel     = s2_ff.last_pixel;
         s3_in.sample         = s2_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

`default_nettype wire

// File: design/fcc_accum.sv
// Frame totals accumulator of the frame change classifier.
`default_nettype none

module fcc_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fcc_pkg::CH_W-1:0]    change_threshold,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  fcc_pkg::diff_type           in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output fcc_pkg::tot_type            out_data
);
   import fcc_pkg::*;

   logic [CNT_W-1:0] changed_ff, changed_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             out_valid_ff, out_valid_in;
   tot_type          tot_ff, tot_in;

   logic             take;
   logic [SUM_W:0]   sum_wide;
   logic [CNT_W-1:0] changed_upd;
   logic [SUM_W-1:0] sum_upd;
   logic [CNT_W-1:0] count_upd;

   assign in_ready = !out_valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(in_data.diff);

   // Saturating totals including the current pixel when it lies on the grid.
   always_comb begin
      changed_upd = changed_ff;
      sum_upd     = sum_ff;
      count_upd   = count_ff;
      if (in_data.sample) begin
         if (count_ff != CNT_MAX) begin
            count_upd = count_ff + CNT_W'(1);
         end
         sum_upd = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
         if ((in_data.diff > change_threshold) && (changed_ff != CNT_MAX)) begin
            changed_upd = changed_ff + CNT_W'(1);
         end
      end
   end

   // The last pixel hands the totals on and starts a fresh frame.
   always_comb begin
      changed_in   = changed_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !out_ready;
      tot_in       = tot_ff;
      if (take) begin
         if (in_data.last_pixel) begin
            changed_in   = '0;
            sum_in       = '0;
            count_in     = '0;
            out_valid_in = 1'b1;
            if (in_data.have_reference) begin
               tot_in.changed = changed_upd;
               tot_in.sum     = sum_upd;
               tot_in.count   = count_upd;
            end else begin
               tot_in = '0;
            end
         end else begin
            changed_in = changed_upd;
            sum_in     = sum_upd;
            count_in   = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         changed_ff   <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         changed_ff   <= changed_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      tot_ff <= tot_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = tot_ff;

endmodule

`default_nettype wire

// File: design/fcc_verdict.sv
// Cross-multiplication and verdict stages of the frame change classifier.
`default_nettype none

module fcc_verdict (
   input  logic                 clock,
   input  logic                 reset,
   input  fcc_pkg::limit_type   limits,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  fcc_pkg::tot_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fcc_pkg::result_type  out_data
);
   import fcc_pkg::*;

   typedef struct packed {
      tot_type           tot;
      logic [MUL_W-1:0]  changed_ppm;
      logic [MUL_W-1:0]  duplicate_lim;
      logic [MUL_W-1:0]  cut_lim;
      logic [MMUL_W-1:0] mean_lim;
   } prod_type;

   logic       s5_valid_ff, s5_valid_in;
   prod_type   s5_ff, s5_in;
   logic       s6_valid_ff, s6_valid_in;
   result_type s6_ff, s6_in;

   logic        s6_ready;
   verdict_type verdict;

   assign s6_ready = !s6_valid_ff || out_ready;
   assign in_ready = !s5_valid_ff || s6_ready;

   // Compare fractions as products, without dividing by the sample count.
   always_comb begin
      verdict = VERDICT_UPDATE;
      if (s5_ff.tot.count != '0) begin
         if (s5_ff.changed_ppm < s5_ff.duplicate_lim) begin
            verdict = VERDICT_DUPLICATE;
         end else if ((s5_ff.changed_ppm > s5_ff.cut_lim) &&
                      (MMUL_W'(s5_ff.tot.sum) > s5_ff.mean_lim)) begin
            verdict = VERDICT_CUT;
         end
      end
   end

   always_comb begin
      s5_valid_in = s5_valid_ff;
      s5_in       = s5_ff;
      if (in_ready) begin
         s5_valid_in         = in_valid;
         s5_in.tot           = in_data;
         s5_in.changed_ppm   = MUL_W'(in_data.changed) * MUL_W'(PPM_ONE);
         s5_in.duplicate_lim = MUL_W'(limits.duplicate_ppm) * MUL_W'(in_data.count);
         s5_in.cut_lim       = MUL_W'(limits.cut_ppm) * MUL_W'(in_data.count);
         s5_in.mean_lim      = MMUL_W'(limits.cut_mean_diff) * MMUL_W'(in_data.count);
      end

      s6_valid_in = s6_valid_ff;
      s6_in       = s6_ff;
      if (s6_ready) begin
         s6_valid_in         = s5_valid_ff;
         s6_in.verdict       = verdict;
         s6_in.changed_count = s5_ff.tot.changed;
         s6_in.diff_sum      = s5_ff.tot.sum;
         s6_in.sample_count  = s5_ff.tot.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
      end
      s5_ff <= s5_in;
      s6_ff <= s6_in;
   end

   assign out_valid = s6_valid_ff;
   assign out_data  = s6_ff;

endmodule

`default_nettype wire

// File: design/frame_change_classifier_unit.sv
// Top level of the frame change classifier: ports, configuration registers and pipeline.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_tvalid/req_tready   tdata pixel pair, tuser reference, tlast
//   rsp      out        rsp_tvalid/rsp_tready   tdata verdict and frame totals
//   csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// One pixel pair is taken per cycle when not stalled by back-pressure or a stride rebuild;
// a result passes the luma, totals and verdict registers. A sample_stride write holds items
// off in its own cycle, then rebuilds the grid phase bit-serially and takes none meanwhile.
// Synchronous reset restores register defaults and clears counters.
// A stalled rsp channel fills the pipeline stages in turn before req_tready drops.
`default_nettype none

module frame_change_classifier_unit (
   input  logic                            clock,
   input  logic                            reset,
   // cur_red, cur_green, cur_blue, ref_red, ref_green, ref_blue
   input  logic [47:0]                     req_tdata,
   // have_reference
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // verdict, changed_count, diff_sum, sample_count, zero fill
   output logic [95:0]                     rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [fcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fcc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            csr_valid,
   output logic                            csr_ready
);
   import fcc_pkg::*;

   `include "frame_change_classifier_unit_macros.svh"

   localparam int RSP_PAD_W = 96 - $bits(result_type);

   logic [FW_W-1:0]     frame_width_ff, frame_width_in;
   logic [STRIDE_W-1:0] sample_stride_ff, sample_stride_in;
   logic [CH_W-1:0]     change_threshold_ff, change_threshold_in;
   limit_type           limits_ff, limits_in;

   logic       csr_write;
   logic       stride_we;
   logic       busy;
   logic       sample;
   logic       pix_accept;
   logic       diff_ready;
   pix_type    pix;
   logic       diff_valid;
   logic       acc_ready;
   diff_type   diff;
   logic       tot_valid;
   logic       verdict_ready;
   tot_type    tot;
   result_type result;

   // Configuration write decode.
   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;
   assign stride_we = csr_write && (csr_index == CSR_SAMPLE_STRIDE);

   always_comb begin
      frame_width_in      = frame_width_ff;
      sample_stride_in    = sample_stride_ff;
      change_threshold_in = change_threshold_ff;
      limits_in           = limits_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:      frame_width_in          = csr_data[FW_W-1:0];
            CSR_SAMPLE_STRIDE:    sample_stride_in        = csr_data[STRIDE_W-1:0];
            CSR_CHANGE_THRESHOLD: change_threshold_in     = csr_data[CH_W-1:0];
            CSR_DUPLICATE_PPM:    limits_in.duplicate_ppm = csr_data[PPM_W-1:0];
            CSR_CUT_PPM:          limits_in.cut_ppm       = csr_data[PPM_W-1:0];
            CSR_CUT_MEAN_DIFF:    limits_in.cut_mean_diff = csr_data[MEAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff          <= FW_W'(1920);
         sample_stride_ff        <= STRIDE_W'(4);
         change_threshold_ff     <= CH_W'(8);
         limits_ff.duplicate_ppm <= PPM_W'(500);
         limits_ff.cut_ppm       <= PPM_W'(500000);
         limits_ff.cut_mean_diff <= MEAN_W'(48);
      end else begin
         frame_width_ff      <= frame_width_in;
         sample_stride_ff    <= sample_stride_in;
         change_threshold_ff <= change_threshold_in;
         limits_ff           <= limits_in;
      end
   end

   // Input handshake and pixel item assembly; a stride write keeps the item waiting.
   assign req_tready = diff_ready && !busy && !stride_we;
   assign pix_accept = req_tvalid && req_tready;

   assign pix.cur_red        = req_tdata[7:0];
   assign pix.cur_green      = req_tdata[15:8];
   assign pix.cur_blue       = req_tdata[23:16];
   assign pix.ref_red        = req_tdata[31:24];
   assign pix.ref_green      = req_tdata[39:32];
   assign pix.ref_blue       = req_tdata[47:40];
   assign pix.have_reference = req_tuser;
   assign pix.last_pixel     = req_tlast;
   assign pix.sample         = sample;

   fcc_position u_position (
      .clock         (clock),
      .reset         (reset),
      .pix_accept    (pix_accept),
      .pix_last      (req_tlast),
      .frame_width   (frame_width_ff),
      .sample_stride (sample_stride_ff),
      .stride_we     (stride_we),
      .stride_new    (csr_data[STRIDE_W-1:0]),
      .sample        (sample),
      .busy          (busy)
   );

   fcc_luma_diff u_luma_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && !busy && !stride_we),
      .in_ready  (diff_ready),
      .in_data   (pix),
      .out_valid (diff_valid),
      .out_ready (acc_ready),
      .out_data  (diff)
   );

   fcc_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .change_threshold (change_threshold_ff),
      .in_valid         (diff_valid),
      .in_ready         (acc_ready),
      .in_data          (diff),
      .out_valid        (tot_valid),
      .out_ready        (verdict_ready),
      .out_data         (tot)
   );

   fcc_verdict u_verdict (
      .clock     (clock),
      .reset     (reset),
      .limits    (limits_ff),
      .in_valid  (tot_valid),
      .in_ready  (verdict_ready),
      .in_data   (tot),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, result};

   // A verdict other than update needs samples, and changes never outnumber samples.
   `FCC_ASSERT_SAME(a_verdict_needs_samples, clock, reset,
      rsp_tvalid && (result.verdict != VERDICT_UPDATE), result.sample_count != '0,
      "non-update verdict with no samples")
   `FCC_ASSERT_SAME(a_changed_within_count, clock, reset,
      rsp_tvalid, result.changed_count <= result.sample_count,
      "changed count exceeds sample count")
   // A stride write must hold off pixel items while the grid phase is rebuilt.
   `FCC_ASSERT_NEXT(a_stride_write_blocks_input, clock, reset,
      stride_we, !req_tready && !csr_ready,
      "pixel item taken during grid phase rebuild")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the frame change classifier: directed frames, then random frames.
module tb_top;
   import fcc_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int TAIL_CYCLES  = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int RUN_LIMIT_NS = 20_000_000;

   // Luma weights in Q0.16, summing to one.
   localparam int unsigned WEIGHT_R = 13933;
   localparam int unsigned WEIGHT_G = 46871;
   localparam int unsigned WEIGHT_B = 4732;
   localparam int unsigned ROUND_HALF = 32768;

   // Indexes past the register list; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 3'd7;

   // One pixel pair as it travels on the request channel.
   typedef struct packed {
      logic [CH_W-1:0] cur_red;
      logic [CH_W-1:0] cur_green;
      logic [CH_W-1:0] cur_blue;
      logic [CH_W-1:0] ref_red;
      logic [CH_W-1:0] ref_green;
      logic [CH_W-1:0] ref_blue;
      logic            have_reference;
      logic            last_pixel;
   } pixel_item_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [47:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [95:0]           rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;

   // Register copies, starting at their reset values.
   logic [FW_W-1:0]     set_width = FW_W'(1920);
   logic [STRIDE_W-1:0] set_stride = STRIDE_W'(4);
   logic [CH_W-1:0]     set_threshold = CH_W'(8);
   logic [PPM_W-1:0]    set_dup_ppm = PPM_W'(500);
   logic [PPM_W-1:0]    set_cut_ppm = PPM_W'(500000);
   logic [MEAN_W-1:0]   set_cut_mean = MEAN_W'(48);

   // Raster position and frame totals of the predictor.
   logic [DIM_W-1:0] at_column = '0;
   logic [DIM_W-1:0] at_row = '0;
   logic [CNT_W-1:0] changed_tot = '0;
   logic [SUM_W:0]   sum_tot = '0;
   logic [CNT_W-1:0] count_tot = '0;

   // Ring of predicted results, written by the predictor and read by the checker.
   result_type  want_mem [64];
   logic [5:0]  want_wr = '0;
   logic [5:0]  want_rd = '0;
   int unsigned fail_count = 0;
   int unsigned send_idle_pct = 9;
   int unsigned recv_idle_pct = 80;
   bit          hold_request = 1'b0;
   bit          hold_seen = 1'b0;
   int unsigned hold_left = 0;

   frame_change_classifier_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Result side: random stalls, and one long hold-off each time it is requested.
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void flag_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Each accepted result is compared with the oldest predicted verdict.
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (want_wr == want_rd) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = want_mem[want_rd];
            want_rd = want_rd + 1'b1;
            flag_field("verdict", 64'(want.verdict), 64'(got.verdict));
            flag_field("changed_count", 64'(want.changed_count), 64'(got.changed_count));
            flag_field("diff_sum", 64'(want.diff_sum), 64'(got.diff_sum));
            flag_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
         end
      end
   end

   function automatic int unsigned luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
   endfunction

   function automatic void clear_totals();
      at_column = '0;
      at_row = '0;
      changed_tot = '0;
      sum_tot = '0;
      count_tot = '0;
   endfunction

   // Advances the raster position and totals by one pixel; on the last pixel the
   // verdict is queued and the totals start afresh.
   function automatic void predict_pixel(pixel_item_t px);
      int unsigned stride, width, luma_cur, luma_prev, gap, diff;
      longint unsigned c, s, n;
      result_type want;
      stride = (set_stride == 0) ? 1 : set_stride;
      width = (set_width == 0) ? 1 : set_width;
      if (width > MAX_DIM)
         width = MAX_DIM;
      if ((at_column % stride) == 0 && (at_row % stride) == 0) begin
         luma_cur = luma_of(px.cur_red, px.cur_green, px.cur_blue);
         luma_prev = luma_of(px.ref_red, px.ref_green, px.ref_blue);
         gap = (luma_cur >= luma_prev) ? luma_cur - luma_prev : luma_prev - luma_cur;
         diff = (gap + ROUND_HALF) >> 16;
         if (count_tot != CNT_MAX)
            count_tot++;
         sum_tot = sum_tot + diff;
         if (sum_tot > SUM_MAX)
            sum_tot = SUM_MAX;
         if (diff > set_threshold && changed_tot != CNT_MAX)
            changed_tot++;
      end
      if (at_column + 1 >= width) begin
         at_column = '0;
         at_row = at_row + 1'b1;
      end else begin
         at_column = at_column + 1'b1;
      end
      if (px.last_pixel) begin
         want.verdict = VERDICT_UPDATE;
         if (!px.have_reference) begin
            want.changed_count = '0;
            want.diff_sum = '0;
            want.sample_count = '0;
         end else begin
            c = changed_tot;
            s = sum_tot;
            n = count_tot;
            want.changed_count = changed_tot;
            want.diff_sum = sum_tot[SUM_W-1:0];
            want.sample_count = count_tot;
            if (n != 0) begin
               if (c * PPM_ONE < set_dup_ppm * n)
                  want.verdict = VERDICT_DUPLICATE;
               else if (c * PPM_ONE > set_cut_ppm * n && s > set_cut_mean * n)
                  want.verdict = VERDICT_CUT;
            end
         end
         want_mem[want_wr] = want;
         want_wr = want_wr + 1'b1;
         clear_totals();
      end
   endfunction

   // Colours are given as {blue, green, red}.
   function automatic pixel_item_t pix(logic [23:0] cur, logic [23:0] prev, bit have,
                                       bit last);
      pixel_item_t px;
      {px.cur_blue, px.cur_green, px.cur_red} = cur;
      {px.ref_blue, px.ref_green, px.ref_red} = prev;
      px.have_reference = have;
      px.last_pixel = last;
      return px;
   endfunction

   // Offers one item after a random gap and predicts it once it is accepted.
   task automatic send_pixel(pixel_item_t px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {px.ref_blue, px.ref_green, px.ref_red,
                    px.cur_blue, px.cur_green, px.cur_red};
      req_tuser <= px.have_reference;
      req_tlast <= px.last_pixel;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_pixel(px);
   endtask

   // Random frame; change_pct sets roughly what share of the pixels differ strongly.
   task automatic send_random_frame(int unsigned len, int unsigned change_pct, bit frame_ref,
                                    bit noisy);
      logic [23:0] prev_rgb, cur_rgb;
      bit          have;
      for (int unsigned i = 0; i < len; i++) begin
         prev_rgb = 24'($urandom);
         if ($urandom_range(99) < change_pct)
            cur_rgb = $urandom_range(1) ? ~prev_rgb : 24'($urandom);
         else
            cur_rgb = $urandom_range(1) ? prev_rgb : prev_rgb ^ (24'($urandom) & 24'h070707);
         have = noisy ? bit'($urandom_range(1)) : frame_ref;
         send_pixel(pix(cur_rgb, prev_rgb, have, i == len - 1));
      end
   endtask

   // Registers change only once the block has delivered everything and settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (want_wr != want_rd) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:      set_width = value[FW_W-1:0];
         CSR_SAMPLE_STRIDE:    set_stride = value[STRIDE_W-1:0];
         CSR_CHANGE_THRESHOLD: set_threshold = value[CH_W-1:0];
         CSR_DUPLICATE_PPM:    set_dup_ppm = value[PPM_W-1:0];
         CSR_CUT_PPM:          set_cut_ppm = value[PPM_W-1:0];
         CSR_CUT_MEAN_DIFF:    set_cut_mean = value[MEAN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reset values: the first and second samples differ fully, the third not at all.
   task automatic test_default_settings();
      send_pixel(pix(24'hFFFFFF, 24'h000000, 1'b1, 1'b0));
      repeat (3) send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b0));
      send_pixel(pix(24'h000000, 24'hFFFFFF, 1'b1, 1'b0));
      repeat (3) send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b0));
      send_pixel(pix(24'h808080, 24'h808080, 1'b1, 1'b1));
   endtask

   // Only the reference flag on the last pixel counts.
   task automatic test_no_reference();
      send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b0));
      send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b0));
      send_pixel(pix(24'hFFFFFF, 24'h000000, 1'b0, 1'b1));
      send_pixel(pix(24'($urandom), 24'($urandom), 1'b0, 1'b0));
      send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b1));
   endtask

   // Thresholds at both ends, and the strict comparisons right at their limit.
   task automatic test_verdict_limits();
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 2);
      write_reg(CSR_SAMPLE_STRIDE, 1);
      write_reg(CSR_CHANGE_THRESHOLD, 0);
      write_reg(CSR_DUPLICATE_PPM, 0);
      write_reg(CSR_CUT_PPM, 0);
      write_reg(CSR_CUT_MEAN_DIFF, 0);
      send_pixel(pix(24'h404040, 24'h404040, 1'b1, 1'b0));
      // A green step of one gives a difference of exactly one.
      send_pixel(pix(24'h004100, 24'h004000, 1'b1, 1'b1));
      wait_idle();
      write_reg(CSR_CHANGE_THRESHOLD, 32'hFF);
      write_reg(CSR_DUPLICATE_PPM, 32'(PPM_ONE));
      write_reg(CSR_CUT_PPM, 32'hFFFFF);
      write_reg(CSR_CUT_MEAN_DIFF, 32'hFF);
      send_pixel(pix(24'hFFFFFF, 24'h000000, 1'b1, 1'b0));
      send_pixel(pix(24'h000000, 24'hFFFFFF, 1'b1, 1'b1));
      wait_idle();
      write_reg(CSR_CHANGE_THRESHOLD, 32'hFE);
      send_pixel(pix(24'hFFFFFF, 24'h000000, 1'b1, 1'b0));
      send_pixel(pix(24'h000000, 24'hFFFFFF, 1'b1, 1'b1));
   endtask

   // Zero width and zero stride behave as one; a wide stride is taken as given.
   task automatic test_grid_edges();
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 0);
      write_reg(CSR_SAMPLE_STRIDE, 0);
      send_random_frame(3, 50, 1'b1, 1'b0);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 3);
      write_reg(CSR_SAMPLE_STRIDE, 31);
      send_random_frame(7, 50, 1'b1, 1'b0);
   endtask

   // Writes past the register list leave every setting as it was.
   task automatic test_unused_index();
      wait_idle();
      write_reg(CSR_UNUSED_LOW, 32'hFFFFF);
      write_reg(CSR_UNUSED_HIGH, $urandom);
      send_random_frame(4, 50, 1'b1, 1'b0);
   endtask

   // Settings changed while a frame is half sent apply from the next pixel.
   task automatic test_mid_frame_write();
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 4);
      write_reg(CSR_SAMPLE_STRIDE, 2);
      write_reg(CSR_CHANGE_THRESHOLD, 10);
      repeat (5) send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b0));
      wait_idle();
      write_reg(CSR_SAMPLE_STRIDE, 1);
      write_reg(CSR_CHANGE_THRESHOLD, 0);
      repeat (5) send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b0));
      send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b1));
   endtask

   // A width beyond the maximum acts as the maximum, so a short frame stays on row zero.
   task automatic test_width_clamp();
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 32'hFFFFF);
      write_reg(CSR_SAMPLE_STRIDE, 4);
      send_random_frame(48, 50, 1'b1, 1'b0);
   endtask

   // With one pixel per row every pixel starts a new row, and every third row is sampled.
   task automatic test_row_wrap();
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 1);
      write_reg(CSR_SAMPLE_STRIDE, 3);
      send_random_frame(40, 50, 1'b1, 1'b0);
   endtask

   // The result side holds off while one-pixel frames keep coming.
   task automatic test_backpressure();
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 1);
      write_reg(CSR_SAMPLE_STRIDE, 1);
      hold_request <= ~hold_request;
      repeat (40) send_pixel(pix(24'($urandom), 24'($urandom), 1'b1, 1'b1));
      wait_idle();
   endtask

   task automatic randomise_settings();
      logic [31:0] value;
      case ($urandom_range(9))
         0:       value = '0;
         1:       value = $urandom;
         default: value = $urandom_range(24, 1);
      endcase
      write_reg(CSR_FRAME_WIDTH, value);
      if ($urandom_range(2) != 0) begin
         case ($urandom_range(6))
            0:       value = $urandom;
            1:       value = '0;
            default: value = $urandom_range(4, 1);
         endcase
         write_reg(CSR_SAMPLE_STRIDE, value);
      end
      if ($urandom_range(2) != 0)
         write_reg(CSR_CHANGE_THRESHOLD, $urandom_range(1) ? $urandom : $urandom_range(20));
      if ($urandom_range(2) != 0) begin
         case ($urandom_range(5))
            0:       value = '0;
            1:       value = 32'(PPM_ONE);
            2:       value = $urandom;
            3:       value = $urandom_range(1000000);
            default: value = $urandom_range(300000);
         endcase
         write_reg(CSR_DUPLICATE_PPM, value);
      end
      if ($urandom_range(2) != 0) begin
         case ($urandom_range(5))
            0:       value = '0;
            1:       value = 32'(PPM_ONE);
            2:       value = $urandom;
            default: value = $urandom_range(1000000);
         endcase
         write_reg(CSR_CUT_PPM, value);
      end
      if ($urandom_range(2) != 0)
         write_reg(CSR_CUT_MEAN_DIFF, $urandom_range(1) ? $urandom : $urandom_range(80));
   endtask

   // Random frames under settings redrawn every few frames.
   task automatic test_random(int unsigned item_budget, int unsigned s_pct, int unsigned r_pct);
      int unsigned sent, frames_left, eff_width, len_cap;
      send_idle_pct <= s_pct;
      recv_idle_pct <= r_pct;
      sent = 0;
      frames_left = 0;
      while (sent < item_budget) begin
         if (frames_left == 0) begin
            wait_idle();
            randomise_settings();
            frames_left = $urandom_range(6, 1);
         end
         eff_width = (set_width == 0) ? 1 : ((set_width > MAX_DIM) ? MAX_DIM : set_width);
         len_cap = eff_width * $urandom_range(5, 1);
         if (len_cap > 60)
            len_cap = 60;
         len_cap = $urandom_range(len_cap, 1);
         send_random_frame(len_cap, $urandom_range(100), $urandom_range(9) != 0,
                           $urandom_range(7) == 0);
         sent += len_cap;
         frames_left--;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_no_reference();
      test_verdict_limits();
      test_grid_edges();
      test_unused_index();
      test_mid_frame_write();
      test_width_clamp();
      test_row_wrap();
      test_backpressure();
      test_random(375, 9, 80);
      test_random(375, 80, 9);
      test_random(375, 0, 0);
      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/fcc_pkg.sv
design/fcc_position.sv
design/fcc_luma_diff.sv
design/fcc_accum.sv
design/fcc_verdict.sv
design/frame_change_classifier_unit.sv
bench/tb_top.sv
